// ===== rtl/euclidean_tour_length_top_macros.svh =====
// Assertion macros used by the tour length controller.
// Needs clk and rst in scope at the point of use.
`ifndef EUCLIDEAN_TOUR_LENGTH_TOP_MACROS_SVH
`define EUCLIDEAN_TOUR_LENGTH_TOP_MACROS_SVH

// Same-cycle implication.
`define ETL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ETL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/etl_pkg.sv =====
// Package for the Euclidean tour length block: widths, request codes and
// the command/status structs between controller and datapath. No dependencies.
package etl_pkg;

  localparam int MAX_CITIES  = 1024;
  localparam int COORD_WIDTH = 20;
  localparam int CITY_W      = 11;
  localparam int ADDR_W      = $clog2(MAX_CITIES);
  localparam int ENTRY_W     = 2 * COORD_WIDTH;
  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam int SQRT_STEPS  = COORD_WIDTH + 1;
  localparam int RAD_W       = 2 * SQRT_STEPS;
  localparam int ROOT_W      = SQRT_STEPS;
  localparam int REM_W       = ROOT_W + 3;
  localparam int CNT_W       = $clog2(SQRT_STEPS);
  localparam int ACC_W       = 32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PATH = 1'b1;

  typedef struct packed {
    logic load;       // write table entry
    logic capture;    // latch path item, issue table read
    logic read;       // table data back: form |dx|, |dy|
    logic mul;        // square the differences
    logic add;        // form radicand, clear root
    logic sqrt_step;  // one root digit
    logic finish;     // accumulate, post result on last
  } dp_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic last;
    logic out_valid;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/etl_ifs.sv =====
// Stream interfaces for request and result beats.
// Depends on etl_pkg.
interface etl_req_if;
  import etl_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [CITY_W-1:0]             city_number;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic                          last_of_path;

  modport source (output valid, req_type, city_number, coord_x, coord_y, last_of_path,
                  input ready);
  modport sink   (input valid, req_type, city_number, coord_x, coord_y, last_of_path,
                  output ready);
endinterface

interface etl_rsp_if;
  import etl_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] tour_length;
  logic             length_saturated;

  modport source (output valid, tour_length, length_saturated, input ready);
  modport sink   (input valid, tour_length, length_saturated, output ready);
endinterface

// ===== rtl/etl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module etl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/etl_ctrl.sv =====
// Sequencer for the tour length block: handshake, step counter for the root.
// Depends on etl_pkg and the assertion macros header.
`include "euclidean_tour_length_top_macros.svh"

module etl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_type,
  output logic            req_ready,
  input  etl_pkg::dp_sts_t sts,
  output etl_pkg::dp_cmd_t cmd
);
  import etl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load    = accept && (req_type == REQ_LOAD);
        cmd.capture = accept && (req_type == REQ_PATH);
        if (cmd.capture) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = sts.have_prev ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + CNT_W'(1);
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold while the previous result is still unclaimed
        if (!(sts.last && sts.out_busy)) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `ETL_ASSERT_NEXT(a_capture_reads, cmd.capture, state == S_READ, "path beat did not start a read")
  `ETL_ASSERT_NEXT(a_add_starts_root, state == S_ADD, state == S_SQRT && cnt == '0, "root not started cleanly")
  `ETL_ASSERT_SAME(a_cnt_range, state == S_SQRT, cnt < CNT_W'(SQRT_STEPS), "root step count overran")
  `ETL_ASSERT_NEXT(a_result_posted, cmd.finish && sts.last, sts.out_valid, "last city gave no result beat")

endmodule

// ===== rtl/etl_dp.sv =====
// Datapath: coordinate table, difference/square/root pipeline, accumulator
// and result register. Depends on etl_pkg and etl_ram.
module etl_dp (
  input  logic                                    clk,
  input  logic                                    rst,
  input  etl_pkg::dp_cmd_t                        cmd,
  output etl_pkg::dp_sts_t                        sts,
  input  logic [etl_pkg::CITY_W-1:0]              city_number,
  input  logic signed [etl_pkg::COORD_WIDTH-1:0]  coord_x,
  input  logic signed [etl_pkg::COORD_WIDTH-1:0]  coord_y,
  input  logic                                    last_of_path,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [etl_pkg::ACC_W-1:0]               tour_length,
  output logic                                    length_saturated
);
  import etl_pkg::*;

  logic                   city_ok, city_ok_q, last_q;
  logic [ADDR_W-1:0]      addr;
  logic [ENTRY_W-1:0]     rdata;

  logic [COORD_WIDTH-1:0] cur_x_w, cur_y_w, cur_x, cur_y, prev_x, prev_y;
  logic signed [COORD_WIDTH:0] ddx, ddy;
  logic [COORD_WIDTH-1:0] dx, dy;
  logic [SQ_W-1:0]        sqx, sqy;
  logic [RAD_W-1:0]       rad;
  logic [REM_W-1:0]       rem, rem_sh, test;
  logic [ROOT_W-1:0]      root;
  logic                   have_prev;
  logic [ACC_W-1:0]       acc;
  logic                   sat;
  logic [ACC_W:0]         sum;
  logic [ACC_W-1:0]       acc_new;
  logic                   sat_new;

  assign city_ok = (city_number != '0) && (city_number <= CITY_W'(MAX_CITIES));
  assign addr    = ADDR_W'(city_number - CITY_W'(1));

  etl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CITIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load && city_ok),
    .waddr (addr),
    .wdata ({coord_x, coord_y}),
    .re    (cmd.capture),
    .raddr (addr),
    .rdata (rdata)
  );

  // Out-of-range city reads as the origin.
  assign cur_x_w = city_ok_q ? rdata[ENTRY_W-1:COORD_WIDTH] : '0;
  assign cur_y_w = city_ok_q ? rdata[COORD_WIDTH-1:0] : '0;
  assign ddx = $signed({cur_x_w[COORD_WIDTH-1], cur_x_w})
             - $signed({prev_x[COORD_WIDTH-1], prev_x});
  assign ddy = $signed({cur_y_w[COORD_WIDTH-1], cur_y_w})
             - $signed({prev_y[COORD_WIDTH-1], prev_y});

  // Root digit: two radicand bits in, trial subtract of 4*root+1.
  assign rem_sh  = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
  assign test    = REM_W'({root, 2'b01});

  assign sum     = {1'b0, acc} + (ACC_W+1)'(root);
  assign acc_new = have_prev ? (sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0]) : acc;
  assign sat_new = sat || (have_prev && sum[ACC_W]);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      city_ok_q <= city_ok;
      last_q    <= last_of_path;
    end
    if (cmd.read) begin
      cur_x <= cur_x_w;
      cur_y <= cur_y_w;
      dx    <= ddx[COORD_WIDTH] ? COORD_WIDTH'(-ddx) : ddx[COORD_WIDTH-1:0];
      dy    <= ddy[COORD_WIDTH] ? COORD_WIDTH'(-ddy) : ddy[COORD_WIDTH-1:0];
    end
    if (cmd.mul) begin
      sqx <= SQ_W'(dx * dx);
      sqy <= SQ_W'(dy * dy);
    end
    if (cmd.add) begin
      rad  <= RAD_W'({1'b0, sqx} + {1'b0, sqy});
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= test) begin
        rem  <= rem_sh - test;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      prev_x <= last_q ? '0 : cur_x;
      prev_y <= last_q ? '0 : cur_y;
      if (last_q) begin
        tour_length      <= acc_new;
        length_saturated <= sat_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      acc       <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        have_prev <= !last_q;
        acc       <= last_q ? '0 : acc_new;
        sat       <= last_q ? 1'b0 : sat_new;
      end
      if (cmd.finish && last_q) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.have_prev = have_prev;
  assign sts.last      = last_q;
  assign sts.out_valid = out_valid;
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

// ===== rtl/euclidean_tour_length_top.sv =====
// A load beat is written as it is accepted. A path beat runs read, diff,
// square, add, 21 root steps and accumulate; the first city of a path skips the
// square, add and root steps. A new beat is taken only after the last is done.
// The result beat is registered and shows the cycle after the last city ends.
// Reset (rst, synchronous) clears the sequencer, accumulator and result valid;
// the coordinate table is not cleared and must be loaded before use.
module euclidean_tour_length_top (
  input logic   clk,
  input logic   rst,
  etl_req_if.sink   req,
  etl_rsp_if.source rsp
);
  import etl_pkg::*;

  // Controller and datapath talk only through these two structs.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: owns the input handshake and counts root digits.
  etl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: table RAM, edge length pipeline, saturating accumulator.
  // The result register lets the next path run while a result waits.
  etl_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .city_number      (req.city_number),
    .coord_x          (req.coord_x),
    .coord_y          (req.coord_y),
    .last_of_path     (req.last_of_path),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .tour_length      (rsp.tour_length),
    .length_saturated (rsp.length_saturated)
  );

endmodule
